[sv/pnq_pkg.sv]
package pnq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam int KEY_W = 35;
    localparam int PAY_W = 52;
    localparam int ID_W  = 16;

    typedef struct packed {
        cmd_t              cmd;
        logic [KEY_W-1:0]  key;   // {kind, time_stamp}
        logic [15:0]       user;
        logic [19:0]       post;
    } req_t;

    typedef struct packed {
        logic [2:0]      kind;
        logic [31:0]     tstamp;
        logic [ID_W-1:0] id;
        logic [15:0]     user;
        logic [19:0]     post;
        logic            last;
    } rsp_t;

endpackage

[sv/pnq_front.sv]
module pnq_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [79:0]         in_data,
    output logic                q_valid,
    input  logic                q_ready,
    output pnq_pkg::req_t       q_req
);
    // two-entry queue holding decoded commands
    pnq_pkg::req_t buf_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    pnq_pkg::req_t dec;
    logic          push, pop;

    always_comb
    begin
        dec.cmd  = pnq_pkg::cmd_t'(in_data[1:0]);
        dec.key  = {in_data[4:2], in_data[36:5]};
        dec.user = in_data[52:37];
        dec.post = in_data[72:53];
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && (dec.cmd != pnq_pkg::CMD_NONE);
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_req    = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[sv/pnq_back.sv]
module pnq_back #(
    parameter int CAPACITY = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  pnq_pkg::req_t   q_req,
    output logic            out_valid,
    input  logic            out_ready,
    output pnq_pkg::rsp_t   out_rsp
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [0:0] { ST_IDLE, ST_READ } state_t;

    // sorted cell chain: each cell compares against the new key in parallel
    logic [pnq_pkg::KEY_W-1:0] key_reg [CAPACITY];
    logic [pnq_pkg::PAY_W-1:0] pay_reg [CAPACITY];
    logic [CW-1:0]             count_reg;
    logic [15:0]               id_reg;
    state_t                    state_reg;
    logic [IW-1:0]             rd_idx_reg;
    logic                      out_valid_reg;
    pnq_pkg::rsp_t             out_reg;
    logic [CAPACITY-1:0]       gt;
    logic [CAPACITY-1:0]       gt_prev;
    logic                      full, do_ins, emit;

    assign full = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i] = (CW'(i) < count_reg) && (key_reg[i] > q_req.key);
        end
    end

    // compare result of the cell below; cell 0 has none
    assign gt_prev = {gt[CAPACITY-2:0], 1'b0};

    assign emit    = (state_reg == ST_READ) && (!out_valid_reg || out_ready);
    assign q_ready = (state_reg == ST_IDLE);
    assign do_ins  = q_valid && q_ready && (q_req.cmd == pnq_pkg::CMD_INSERT) && !full;

    always_ff @(posedge clk)
    begin
        if (do_ins)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                // first greater cell takes the new item, later ones shift up
                if (gt[i] && !gt_prev[i])
                begin
                    key_reg[i] <= q_req.key;
                    pay_reg[i] <= {id_reg, q_req.user, q_req.post};
                end
                else if (gt_prev[i])
                begin
                    key_reg[i] <= key_reg[(i > 0) ? i - 1 : 0];
                    pay_reg[i] <= pay_reg[(i > 0) ? i - 1 : 0];
                end
                else if (CW'(i) == count_reg)
                begin
                    key_reg[i] <= q_req.key;
                    pay_reg[i] <= {id_reg, q_req.user, q_req.post};
                end
            end
        end
        if (emit)
        begin
            out_reg.kind   <= key_reg[rd_idx_reg][34:32];
            out_reg.tstamp <= key_reg[rd_idx_reg][31:0];
            out_reg.id     <= pay_reg[rd_idx_reg][51:36];
            out_reg.user   <= pay_reg[rd_idx_reg][35:20];
            out_reg.post   <= pay_reg[rd_idx_reg][19:0];
            out_reg.last   <= (CW'(rd_idx_reg) + CW'(1) == count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            id_reg        <= 16'd1;
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        unique case (q_req.cmd)
                            pnq_pkg::CMD_INSERT:
                            begin
                                if (!full)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                    id_reg    <= (id_reg == 16'hFFFF) ? 16'd1 : id_reg + 16'd1;
                                end
                            end
                            pnq_pkg::CMD_READ:
                            begin
                                rd_idx_reg <= '0;
                                if (count_reg != '0)
                                begin
                                    state_reg <= ST_READ;
                                end
                            end
                            pnq_pkg::CMD_CLEAR: count_reg <= '0;
                            default: ;
                        endcase
                    end
                end
                ST_READ:
                begin
                    if (emit)
                    begin
                        out_valid_reg <= 1'b1;
                        rd_idx_reg    <= rd_idx_reg + IW'(1);
                        if (CW'(rd_idx_reg) + CW'(1) == count_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;
endmodule

[sv/priority_notification_queue.sv]
// Bounded priority queue of notification records. Insert (command 0) stores an entry with a
// running id (1..65535, wraps to 1) unless full, in which case it is dropped; read-all
// (command 1) streams every entry by kind, then timestamp, then insertion order, with tlast on
// the final one and nothing when empty; clear (command 2) empties it. Inserts and clears pass
// through the two-entry command queue before the back end applies them; a read-all streams
// the stored entries, paced by the single output register. Entries live in a chain of sorted
// cells that all compare against a new key at once.
module priority_notification_queue #(
    parameter int CAPACITY = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // command[1:0], kind[4:2], time_stamp[36:5], from_user[52:37], post[72:53], zero fill
    input  logic [79:0]   s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // notif_id[15:0], out_kind[18:16], out_time[50:19], out_user[66:51], out_post[86:67], fill
    output logic [87:0]   m_axis_tdata,
    output logic          m_axis_tlast
);
    logic          q_valid, q_ready;
    pnq_pkg::req_t q_req;
    pnq_pkg::rsp_t rsp;

    pnq_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    pnq_back #(.CAPACITY(CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp)
    );

    assign m_axis_tdata = {1'b0, rsp.post, rsp.user, rsp.tstamp, rsp.kind, rsp.id};
    assign m_axis_tlast = rsp.last;
endmodule

[sv/pnq_checker.sv]
module pnq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // output payload holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // identifiers are never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] != 16'd0)
        else $error("zero id emitted");

    // within a run, kinds never decrease
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
        |-> m_axis_tdata[18:16] >= $past(m_axis_tdata[18:16]))
        else $error("priority order broken");
endmodule

bind priority_notification_queue pnq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

[verif/pnq_checker.sv]
module pnq_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [87:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    localparam int DEPTH = 32;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  kind;
        logic [31:0] tstamp;
        logic [15:0] user;
        logic [19:0] post;
        logic        last;
    } notif_t;

    notif_t      sorted_store [DEPTH];
    int          stored;
    logic [15:0] id_next;
    notif_t      emit_queue [$];

    assign pending = emit_queue.size();

    // Insertion behind every entry with an equal or smaller {kind, time} key keeps ties in order.
    task automatic model_transfer(input logic [79:0] d);
        pnq_pkg::cmd_t cmd;
        notif_t        rec;
        int            pos;
        begin
            cmd = pnq_pkg::cmd_t'(d[1:0]);
            case (cmd)
                pnq_pkg::CMD_INSERT:
                    if (stored < DEPTH)
                    begin
                        rec.id = id_next;
                        rec.kind = d[4:2];
                        rec.tstamp = d[36:5];
                        rec.user = d[52:37];
                        rec.post = d[72:53];
                        rec.last = 1'b0;
                        pos = 0;
                        while (pos < stored && {sorted_store[pos].kind, sorted_store[pos].tstamp}
                               <= {rec.kind, rec.tstamp})
                            pos++;
                        for (int i = stored; i > pos; i--)
                            sorted_store[i] = sorted_store[i-1];
                        sorted_store[pos] = rec;
                        stored++;
                        id_next = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
                    end
                pnq_pkg::CMD_READ:
                    for (int i = 0; i < stored; i++)
                    begin
                        rec = sorted_store[i];
                        rec.last = (i == stored - 1);
                        emit_queue.push_back(rec);
                    end
                pnq_pkg::CMD_CLEAR:
                    stored = 0;
                default: ;
            endcase
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        notif_t want;
        if (!rst_n)
        begin
            stored = 0;
            id_next = 16'd1;
            fail_count = 0;
            emit_queue.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (emit_queue.size() == 0)
                begin
                    $error("unexpected output transfer %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = emit_queue.pop_front();
                    compare_field("notif_id", 32'(want.id), 32'(m_axis_tdata[15:0]));
                    compare_field("out_kind", 32'(want.kind), 32'(m_axis_tdata[18:16]));
                    compare_field("out_time", want.tstamp, m_axis_tdata[50:19]);
                    compare_field("out_user", 32'(want.user), 32'(m_axis_tdata[66:51]));
                    compare_field("out_post", 32'(want.post), 32'(m_axis_tdata[86:67]));
                    compare_field("last", 32'(want.last), 32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                model_transfer(s_axis_tdata);
        end
    end
endmodule

[verif/tb.sv]
module tb;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // command, kind, time_stamp, from_user, post, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;   // notif_id, out_kind, out_time, out_user, out_post, fill
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;

    // Idle percentages for sender and receiver, set per phase.
    int          send_idle_pct;
    int          recv_stall_pct;

    priority_notification_queue u_top (.*);

    pnq_scoreboard u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random backpressure at the current stall rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One transfer: optional idle gaps, then hold tvalid until accepted.
    task automatic send(input pnq_pkg::cmd_t cmd, input logic [2:0] kind, input logic [31:0] ts,
                        input logic [15:0] user, input logic [19:0] post);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, post, user, ts, kind, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random_insert();
        send(pnq_pkg::CMD_INSERT, 3'($urandom),
             ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom,
             16'($urandom), 20'($urandom));
    endtask

    initial
    begin
        int pick;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty read, unused code, extremes, ties, clear.
        send(pnq_pkg::CMD_READ, 3'd0, 32'd0, 16'd0, 20'd0);
        send(pnq_pkg::CMD_NONE, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 20'hF_FFFF);
        send(pnq_pkg::CMD_INSERT, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 20'hF_FFFF);
        send(pnq_pkg::CMD_INSERT, 3'd0, 32'd0, 16'd0, 20'd0);
        send(pnq_pkg::CMD_INSERT, 3'd3, 32'd100, 16'h1234, 20'h5_5555);
        send(pnq_pkg::CMD_INSERT, 3'd3, 32'd100, 16'h4321, 20'hA_AAAA);   // tie: after previous
        send(pnq_pkg::CMD_INSERT, 3'd3, 32'd50, 16'h0001, 20'h0_0001);
        send(pnq_pkg::CMD_READ, 3'd0, 32'd0, 16'd0, 20'd0);
        send(pnq_pkg::CMD_CLEAR, 3'd0, 32'd0, 16'd0, 20'd0);
        send(pnq_pkg::CMD_READ, 3'd0, 32'd0, 16'd0, 20'd0);
        // Fill past capacity: extra inserts are dropped.
        for (int i = 0; i < 34; i++)
            send_random_insert();
        send(pnq_pkg::CMD_READ, 3'd0, 32'd0, 16'd0, 20'd0);
        send(pnq_pkg::CMD_CLEAR, 3'd0, 32'd0, 16'd0, 20'd0);

        // Random phases with the different idle patterns.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 36 : 59) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 36 : 59) : 0;
            for (int n = 0; n < 60; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_random_insert();
                else if (pick < 88)
                    send(pnq_pkg::CMD_READ, 3'($urandom), $urandom, 16'($urandom),
                         20'($urandom));
                else if (pick < 96)
                    send(pnq_pkg::CMD_CLEAR, 3'($urandom), $urandom, 16'($urandom),
                         20'($urandom));
                else
                    send(pnq_pkg::CMD_NONE, 3'($urandom), $urandom, 16'($urandom),
                         20'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 20; i++)
            send_random_insert();
        send(pnq_pkg::CMD_READ, 3'd0, 32'd0, 16'd0, 20'd0);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("tb: done, errors");
        $finish;
    end
endmodule

[files.f]
sv/pnq_pkg.sv
sv/pnq_front.sv
sv/pnq_back.sv
sv/priority_notification_queue.sv
sv/pnq_checker.sv
verif/pnq_checker.sv
verif/tb.sv
